FILE: hdl/nrpc_pkg.sv
`timescale 1ns / 1ps

package nrpc_pkg;

    localparam int PALETTE_SIZE  = 40;
    localparam int TABLE_ENTRIES = 40;
    localparam int SEARCH_LEN    = (PALETTE_SIZE > TABLE_ENTRIES) ? TABLE_ENTRIES : PALETTE_SIZE;
    localparam int IDX_W         = 6;
    localparam int DIST_W        = 18;
    localparam int COLOR_W       = 32;
    localparam int RGB_W         = 24;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEARCH_LEN - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic alpha_zero;
    } t_status;

    // entries as 0xBBGGRR
    function automatic logic [RGB_W-1:0] palette_rgb(input logic [IDX_W-1:0] idx);
        logic [RGB_W-1:0] p;
        unique case (idx)
            6'd0:  p = 24'h000000;
            6'd1:  p = 24'h002AA5;
            6'd2:  p = 24'h404000;
            6'd3:  p = 24'h005500;
            6'd4:  p = 24'h5E0000;
            6'd5:  p = 24'h8B0000;
            6'd6:  p = 24'h82004B;
            6'd7:  p = 24'h282828;
            6'd8:  p = 24'h00008B;
            6'd9:  p = 24'h2068FF;
            6'd10: p = 24'h008B8B;
            6'd11: p = 24'h009300;
            6'd12: p = 24'h8E8E38;
            6'd13: p = 24'hFF0000;
            6'd14: p = 24'hC07B7B;
            6'd15: p = 24'h666666;
            6'd16: p = 24'h0000FF;
            6'd17: p = 24'h5BADFF;
            6'd18: p = 24'h32CD32;
            6'd19: p = 24'h71B33C;
            6'd20: p = 24'hD4FF7F;
            6'd21: p = 24'hC09E7D;
            6'd22: p = 24'h800080;
            6'd23: p = 24'h7F7F7F;
            6'd24: p = 24'hCBC0FF;
            6'd25: p = 24'h00D7FF;
            6'd26: p = 24'h00FFFF;
            6'd27: p = 24'h00FF00;
            6'd28: p = 24'hD0E040;
            6'd29: p = 24'hFFFFC0;
            6'd30: p = 24'h480048;
            6'd31: p = 24'hC0C0C0;
            6'd32: p = 24'hE1E4FF;
            6'd33: p = 24'h8CB4D2;
            6'd34: p = 24'hE0FFFF;
            6'd35: p = 24'h98FB98;
            6'd36: p = 24'hEEEEAF;
            6'd37: p = 24'h8B8368;
            6'd38: p = 24'hFAE6E6;
            6'd39: p = 24'hFFFFFF;
            default: p = 24'h000000;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/nrpc_ctrl.sv
`timescale 1ns / 1ps

module nrpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  nrpc_pkg::t_status i_status,
    output nrpc_pkg::t_cmd    o_cmd
);

    nrpc_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nrpc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            nrpc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_status.alpha_zero ? nrpc_pkg::ST_DONE : nrpc_pkg::ST_SEARCH;
                end
            end
            nrpc_pkg::ST_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    n_state = nrpc_pkg::ST_DONE;
                end
            end
            nrpc_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = nrpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nrpc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/nrpc_dp.sv
`timescale 1ns / 1ps

module nrpc_dp (
    input  logic                           i_clk,
    input  logic [nrpc_pkg::COLOR_W-1:0]   i_color_word,
    input  nrpc_pkg::t_cmd                 i_cmd,
    output nrpc_pkg::t_status              o_status,
    output logic                           o_is_transparent,
    output logic [nrpc_pkg::IDX_W-1:0]     o_palette_index
);

    logic [nrpc_pkg::RGB_W-1:0]  r_color;
    logic [nrpc_pkg::IDX_W-1:0]  r_idx;
    logic [nrpc_pkg::DIST_W-1:0] r_best_dist;
    logic [nrpc_pkg::IDX_W-1:0]  r_best_idx;
    logic                        r_transparent;
    logic                        r_out_transparent;
    logic [nrpc_pkg::IDX_W-1:0]  r_out_index;

    logic [nrpc_pkg::RGB_W-1:0]  entry;
    logic [7:0]                  diff [3];
    logic [15:0]                 sq   [3];
    logic [nrpc_pkg::DIST_W-1:0] cur_dist;
    logic                        take;

    always_comb begin
        entry = nrpc_pkg::palette_rgb(r_idx);
        for (int k = 0; k < 3; k++) begin
            diff[k] = (entry[8*k +: 8] > r_color[8*k +: 8])
                    ? entry[8*k +: 8] - r_color[8*k +: 8]
                    : r_color[8*k +: 8] - entry[8*k +: 8];
            sq[k]   = diff[k] * diff[k];
        end
        cur_dist = nrpc_pkg::DIST_W'(sq[0]) + nrpc_pkg::DIST_W'(sq[1])
                 + nrpc_pkg::DIST_W'(sq[2]);
        take = (r_idx == '0) || (cur_dist < r_best_dist);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_color       <= i_color_word[nrpc_pkg::RGB_W-1:0];
            r_transparent <= (i_color_word[31:24] == 8'd0);
            r_idx         <= '0;
            r_best_idx    <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
            if (take) begin
                r_best_dist <= cur_dist;
                r_best_idx  <= r_idx;
            end
        end
        if (i_cmd.publish) begin
            r_out_transparent <= r_transparent;
            r_out_index       <= r_best_idx;
        end
    end

    assign o_status.last       = (r_idx == nrpc_pkg::LAST_IDX);
    assign o_status.alpha_zero = (i_color_word[31:24] == 8'd0);
    assign o_is_transparent    = r_out_transparent;
    assign o_palette_index     = r_out_index;

endmodule

FILE: hdl/nearest_palette_color.sv
`timescale 1ns / 1ps
// Channel    | Direction | Payload
// s_axis     | in        | tdata[31:0] color_word
// m_axis     | out       | tdata[5:0] palette_index, tuser is_transparent
//
// Opaque item: load, then scan 40 palette entries at one entry per cycle,
// then publish; a transparent item goes straight from load to publish.
// The single shared distance unit sets the scan rate.
// Synchronous active-low reset clears the controller and the output valid.
// A stalled result holds in the output register while the next item is
// accepted and scanned; it then waits for the output to drain.

module nearest_palette_color (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] color_word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [5:0] palette_index, [7:6] zero
    output logic        o_m_axis_tuser    // [0] is_transparent
);

    nrpc_pkg::t_cmd                cmd;
    nrpc_pkg::t_status             status;
    logic [nrpc_pkg::IDX_W-1:0]    palette_index;

    nrpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    nrpc_dp u_dp (
        .i_clk            (i_clk),
        .i_color_word     (i_s_axis_tdata),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_is_transparent (o_m_axis_tuser),
        .o_palette_index  (palette_index)
    );

    assign o_m_axis_tdata = {2'b00, palette_index};

endmodule

FILE: tb/nearest_palette_color_tb.sv
`timescale 1ns / 1ps

module nearest_palette_color_tb;

    typedef struct packed {
        logic                       is_transparent;
        logic [nrpc_pkg::IDX_W-1:0] palette_index;
    } t_match;

    // entries as 0xBBGGRR
    localparam logic [23:0] SWATCH [0:39] = '{
        24'h000000, 24'h002AA5, 24'h404000, 24'h005500, 24'h5E0000,
        24'h8B0000, 24'h82004B, 24'h282828, 24'h00008B, 24'h2068FF,
        24'h008B8B, 24'h009300, 24'h8E8E38, 24'hFF0000, 24'hC07B7B,
        24'h666666, 24'h0000FF, 24'h5BADFF, 24'h32CD32, 24'h71B33C,
        24'hD4FF7F, 24'hC09E7D, 24'h800080, 24'h7F7F7F, 24'hCBC0FF,
        24'h00D7FF, 24'h00FFFF, 24'h00FF00, 24'hD0E040, 24'hFFFFC0,
        24'h480048, 24'hC0C0C0, 24'hE1E4FF, 24'h8CB4D2, 24'hE0FFFF,
        24'h98FB98, 24'hEEEEAF, 24'h8B8368, 24'hFAE6E6, 24'hFFFFFF
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = 32'd0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tuser;

    logic [31:0] color_q[$];
    t_match      match_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic holdoff_req = 1'b0;
    int holdoff_cnt = 0;

    int err_cnt = 0;
    int sent_cnt = 0;
    int checked_cnt = 0;
    int clear_cnt = 0;

    nearest_palette_color u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),          // [31:0] color_word
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [5:0] palette_index, [7:6] zero
        .o_m_axis_tuser  (o_m_axis_tuser)    // [0] is_transparent
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_match nearest_entry(input logic [31:0] color);
        t_match m;
        int best_dist;
        int sq_dist;
        int dr;
        int dg;
        int db;
        m.is_transparent = 1'b0;
        m.palette_index = '0;
        best_dist = 1000000;
        if (color[31:24] == 8'd0) begin
            m.is_transparent = 1'b1;
            return m;
        end
        for (int i = 0; i < nrpc_pkg::SEARCH_LEN && i < 40; i++) begin
            dr = int'(SWATCH[i][7:0]) - int'(color[7:0]);
            dg = int'(SWATCH[i][15:8]) - int'(color[15:8]);
            db = int'(SWATCH[i][23:16]) - int'(color[23:16]);
            sq_dist = dr * dr + dg * dg + db * db;
            if (sq_dist < best_dist) begin
                best_dist = sq_dist;
                m.palette_index = nrpc_pkg::IDX_W'(i);
            end
        end
        return m;
    endfunction

    function automatic logic [31:0] random_color();
        int pick;
        int a;
        int b;
        int v;
        logic [7:0] alpha;
        logic [23:0] rgb;
        pick = $urandom_range(99);
        a = $urandom_range(39);
        b = $urandom_range(39);
        rgb = 24'($urandom());
        case ($urandom_range(3))
            0: alpha = 8'd0;
            1, 2: alpha = 8'hFF;
            default: alpha = 8'($urandom_range(255, 1));
        endcase
        if (pick < 20) begin
            return {8'd0, rgb};
        end else if (pick < 55) begin
            for (int k = 0; k < 3; k++) begin
                v = int'(SWATCH[a][8*k +: 8]) + int'($urandom_range(12)) - 6;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                rgb[8*k +: 8] = 8'(v);
            end
        end else if (pick < 75) begin
            // midway between two entries: ties are likely here
            for (int k = 0; k < 3; k++) begin
                v = (int'(SWATCH[a][8*k +: 8]) + int'(SWATCH[b][8*k +: 8])) / 2;
                rgb[8*k +: 8] = 8'(v);
            end
        end else begin
            return $urandom();
        end
        if (alpha == 8'd0) alpha = 8'h01;
        return {alpha, rgb};
    endfunction

    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_axis_tready) begin
            if (s_tvalid) begin
                match_q.push_back(nearest_entry(s_tdata));
                sent_cnt++;
            end
            if (color_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= color_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff_cnt <= 0;
        end else if (holdoff_req) begin
            holdoff_cnt <= 400;
        end else if (holdoff_cnt != 0) begin
            holdoff_cnt <= holdoff_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        t_match want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                if (match_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected item tdata=%h tuser=%b",
                                            o_m_axis_tdata, o_m_axis_tuser));
                end else begin
                    want = match_q.pop_front();
                    checked_cnt++;
                    if (want.is_transparent) clear_cnt++;
                    if (o_m_axis_tuser !== want.is_transparent ||
                        o_m_axis_tdata !== {2'b00, want.palette_index}) begin
                        flag_mismatch($sformatf(
                            "item %0d: got transparent=%b tdata=%h, want %b index=%0d",
                            checked_cnt, o_m_axis_tuser, o_m_axis_tdata,
                            want.is_transparent, want.palette_index));
                    end
                end
            end
            m_tready <= (holdoff_cnt == 0) && !holdoff_req &&
                        ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_random(input int n);
        @(negedge i_clk);
        repeat (n) color_q.push_back(random_color());
    endtask

    task automatic wait_drained();
        while (color_q.size() != 0 || s_tvalid || match_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        color_q.push_back(32'h0000_0000);
        color_q.push_back(32'h00FF_FFFF);
        color_q.push_back(32'h0012_3456);
        color_q.push_back(32'hFF00_0000);
        color_q.push_back(32'hFFFF_FFFF);
        color_q.push_back(32'h01FF_FFFF);
        color_q.push_back(32'h0100_0000);
        color_q.push_back(32'h80FF_00FF);
        color_q.push_back(32'hFF00_00FF);
        color_q.push_back(32'hFF00_FF00);
        color_q.push_back(32'hFFFF_0000);
        color_q.push_back(32'hFF14_1414);   // equal distance to black and dark gray
        color_q.push_back(32'hFF7F_7F7F);
        color_q.push_back(32'hFF80_8080);
        color_q.push_back(32'hFF60_6060);
        color_q.push_back({8'hC3, SWATCH[1]});
        color_q.push_back({8'h7E, SWATCH[9]});
        color_q.push_back({8'hFF, SWATCH[20]});
        color_q.push_back({8'h01, SWATCH[29]});
        color_q.push_back({8'hFF, SWATCH[38]});
        color_q.push_back({8'hFE, SWATCH[39] ^ 24'h010101});
        color_q.push_back(32'hAA55_AA55);
        color_q.push_back(32'h55AA_55AA);
        queue_random(150);
        wait_drained();

        set_idling(52, 0);
        queue_random(150);
        wait_drained();

        set_idling(0, 52);
        queue_random(150);
        wait_drained();

        set_idling(38, 38);
        queue_random(150);
        wait_drained();

        // hold off the output while the input keeps offering
        set_idling(0, 0);
        queue_random(150);
        @(posedge i_clk);
        holdoff_req <= 1'b1;
        @(posedge i_clk);
        holdoff_req <= 1'b0;
        @(posedge i_clk);
        while (holdoff_cnt != 0) @(posedge i_clk);
        wait_drained();

        repeat (100) @(posedge i_clk);
        if (match_q.size() != 0)
            flag_mismatch($sformatf("%0d expected items never arrived", match_q.size()));

        $display("Covered %0d colors (%0d transparent) over no-idle, sender-idle,",
                 checked_cnt, clear_cnt);
        $display("receiver-stall, mixed and long-backpressure phases; %0d errors",
                 err_cnt);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout: sent %0d, checked %0d", sent_cnt, checked_cnt);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
